/* rtl/php_pkg.sv */
// package for the pulse height histogram
// types, constants and opcodes for the php modules (php_ram does not use them); no dependencies
package php_pkg;

  localparam int NUM_BINS    = 2048;
  localparam int SAMPLE_BITS = 12;
  localparam int BIN_AW      = $clog2(NUM_BINS);
  localparam int COUNT_W     = 24;
  localparam int ADC_W       = 12;
  localparam int INDEX_W     = 11;

  typedef enum logic [1:0] {
    OP_PULSE = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [ADC_W-1:0]   adc_sample;
    logic [INDEX_W-1:0] bin_index;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] bin_count;
    logic               measuring;
    logic               accepted;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    logic              incr;
    logic [BIN_AW-1:0] addr;
  } rmw_req_t;

  typedef struct packed {
    logic               busy;
    logic [COUNT_W-1:0] count;
  } rmw_rsp_t;

endpackage

/* rtl/php_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module php_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/php_bin_rmw.sv */
// bin store read-modify-write: clearing pass, registered read, increment and write back
// with forwarding of the last write; depends on php_pkg and php_ram
module php_bin_rmw (
  input  logic              clk,
  input  logic              rst_n,
  input  php_pkg::rmw_req_t req,
  output php_pkg::rmw_rsp_t rsp
);

  logic                         clr_active_r;
  logic [php_pkg::BIN_AW-1:0]   clr_addr_r;
  logic                         s_valid_r;
  logic                         s_incr_r;
  logic [php_pkg::BIN_AW-1:0]   s_addr_r;
  logic                         fwd_valid_r;
  logic [php_pkg::BIN_AW-1:0]   fwd_addr_r;
  logic [php_pkg::COUNT_W-1:0]  fwd_data_r;
  logic [php_pkg::COUNT_W-1:0]  rd_data;
  logic [php_pkg::COUNT_W-1:0]  cur_count;
  logic [php_pkg::COUNT_W-1:0]  inc_count;
  logic                         inc_wr;
  logic                         wr_en;
  logic [php_pkg::BIN_AW-1:0]   wr_addr;
  logic [php_pkg::COUNT_W-1:0]  wr_data;

  php_ram #(
    .WIDTH (php_pkg::COUNT_W),
    .DEPTH (php_pkg::NUM_BINS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (req.valid),
    .rd_addr (req.addr),
    .rd_data (rd_data)
  );

  // the read issued at the same edge as the previous write sees stale data
  assign cur_count = (fwd_valid_r && fwd_addr_r == s_addr_r) ? fwd_data_r : rd_data;
  assign inc_count = cur_count + php_pkg::COUNT_W'(1);
  assign inc_wr    = s_valid_r && s_incr_r;

  always_comb begin
    if (clr_active_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else begin
      wr_en   = inc_wr;
      wr_addr = s_addr_r;
      wr_data = inc_count;
    end
  end

  assign rsp.busy  = clr_active_r;
  assign rsp.count = cur_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      s_valid_r    <= 1'b0;
      fwd_valid_r  <= 1'b0;
    end else begin
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + php_pkg::BIN_AW'(1);
        if (clr_addr_r == php_pkg::BIN_AW'(php_pkg::NUM_BINS - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
      s_valid_r   <= req.valid;
      fwd_valid_r <= inc_wr;
    end
  end

  always_ff @(posedge clk) begin
    s_incr_r   <= req.incr;
    s_addr_r   <= req.addr;
    fwd_addr_r <= s_addr_r;
    fwd_data_r <= inc_count;
  end

  a_no_access_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !s_valid_r && !fwd_valid_r)
    else $error("bin access during clearing pass");

  a_fwd_holds_written_value: assert property (@(posedge clk) disable iff (!rst_n)
    inc_wr |=> fwd_valid_r && fwd_data_r == $past(inc_count))
    else $error("forwarding register lost an increment");

endmodule

/* rtl/pulse_height_histogram.sv */
// pulse height histogram: each accepted transaction passes the s1 stage and the output
// register before its result strobe; throughput one transaction per cycle while busy is low,
// any op mix (back-to-back hits on one bin are forwarded around the ram read)
// after reset busy stays high while every bin of the ram is cleared
// no output stall; depends on php_pkg, php_bin_rmw and php_ram
module pulse_height_histogram (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  php_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output php_pkg::out_item_t out_item
);

  logic                        accept;
  logic                        run_flag_r;
  logic                        run_nxt;
  logic [php_pkg::ADC_W-1:0]   sample_m;
  logic [php_pkg::ADC_W-2:0]   bin_w;
  logic                        is_pulse;
  logic                        is_read;
  logic                        pulse_ok;
  logic                        read_ok;
  logic                        item_ok;
  php_pkg::rmw_req_t           req;
  php_pkg::rmw_rsp_t           rsp;
  logic                        s1_valid_r;
  logic                        s1_read_r;
  logic                        s1_meas_r;
  logic                        s1_ok_r;
  logic                        out_strobe_r;
  php_pkg::out_item_t          out_item_r;

  assign accept   = start && !busy;
  assign sample_m = in_item.adc_sample
                  & php_pkg::ADC_W'((1 << php_pkg::SAMPLE_BITS) - 1);
  assign bin_w    = sample_m[php_pkg::ADC_W-1:1];
  assign is_pulse = in_item.op == php_pkg::OP_PULSE;
  assign is_read  = in_item.op == php_pkg::OP_READ;
  assign pulse_ok = run_flag_r && (32'(bin_w) < php_pkg::NUM_BINS);
  assign read_ok  = 32'(in_item.bin_index) < php_pkg::NUM_BINS;

  always_comb begin
    run_nxt = run_flag_r;
    item_ok = 1'b0;
    case (in_item.op)
      php_pkg::OP_PULSE: item_ok = pulse_ok;
      php_pkg::OP_START: begin
        item_ok = !run_flag_r;
        run_nxt = 1'b1;
      end
      php_pkg::OP_STOP: begin
        item_ok = run_flag_r;
        run_nxt = 1'b0;
      end
      php_pkg::OP_READ: item_ok = read_ok;
      default: item_ok = 1'b0;
    endcase
  end

  assign req.valid = accept && ((is_pulse && pulse_ok) || (is_read && read_ok));
  assign req.incr  = is_pulse;
  assign req.addr  = is_pulse ? bin_w[php_pkg::BIN_AW-1:0]
                              : in_item.bin_index[php_pkg::BIN_AW-1:0];

  php_bin_rmw u_rmw (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign busy = rsp.busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_flag_r   <= 1'b0;
      s1_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (accept) begin
        run_flag_r <= run_nxt;
      end
      s1_valid_r   <= accept;
      out_strobe_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_read_r <= is_read && read_ok;
    s1_meas_r <= run_nxt;
    s1_ok_r   <= item_ok;
    out_item_r.bin_count <= s1_read_r ? rsp.count : '0;
    out_item_r.measuring <= s1_meas_r;
    out_item_r.accepted  <= s1_ok_r;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !s1_valid_r)
    else $error("transaction taken during clearing pass");

  a_reject_has_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && !out_item_r.accepted |-> out_item_r.bin_count == '0)
    else $error("rejected transaction carries a count");

  a_measuring_tracks_flag: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> s1_meas_r == run_flag_r)
    else $error("reported run state differs from run flag");

endmodule

/* bench/pulse_height_histogram_tb.sv */
// testbench for pulse_height_histogram (needs php_pkg and the rtl): directed table, then
// measurement bursts; typed rows are checked against the table, the rest against an in-bench histogram model
`timescale 1ns / 1ps

module pulse_height_histogram_tb;

  localparam int DIR_ROWS   = 22;
  localparam int RAND_ITEMS = 1100;
  localparam int CYCLE_CAP  = 100000;
  localparam int TAIL_WAIT  = 8;

  typedef struct packed {
    php_pkg::op_t                op;
    logic [php_pkg::ADC_W-1:0]   adc;
    logic [php_pkg::INDEX_W-1:0] idx;
    logic                        typed;
    logic [php_pkg::COUNT_W-1:0] cnt;
    logic                        meas;
    logic                        acc;
  } dir_row_t;

  typedef struct packed {
    php_pkg::in_item_t  item;
    logic               typed;
    php_pkg::out_item_t want;
    logic               quiet;
  } stim_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  php_pkg::in_item_t  in_item;
  logic               out_strobe;
  php_pkg::out_item_t out_item;

  logic               row_typed;
  php_pkg::out_item_t row_want;

  logic [php_pkg::COUNT_W-1:0] hist_counts [php_pkg::NUM_BINS];
  logic                        run_on;

  php_pkg::out_item_t pending_results [$];
  stim_t              stim_q [$];
  int                 accept_cnt;
  int                 fail_cnt;
  int                 cycle_cnt;

  dir_row_t dir_table [DIR_ROWS] = '{
    '{php_pkg::OP_READ,  12'h000, 11'h000, 1'b1, 24'd0, 1'b0, 1'b1},
    '{php_pkg::OP_READ,  12'h000, 11'h7ff, 1'b1, 24'd0, 1'b0, 1'b1},
    '{php_pkg::OP_PULSE, 12'hfff, 11'h000, 1'b1, 24'd0, 1'b0, 1'b0},
    '{php_pkg::OP_STOP,  12'h000, 11'h000, 1'b1, 24'd0, 1'b0, 1'b0},
    '{php_pkg::OP_START, 12'h000, 11'h000, 1'b1, 24'd0, 1'b1, 1'b1},
    '{php_pkg::OP_START, 12'h000, 11'h000, 1'b1, 24'd0, 1'b1, 1'b0},
    '{php_pkg::OP_PULSE, 12'h000, 11'h7ff, 1'b1, 24'd0, 1'b1, 1'b1},
    '{php_pkg::OP_PULSE, 12'h001, 11'h000, 1'b1, 24'd0, 1'b1, 1'b1},
    '{php_pkg::OP_PULSE, 12'hfff, 11'h000, 1'b1, 24'd0, 1'b1, 1'b1},
    '{php_pkg::OP_PULSE, 12'hffe, 11'h000, 1'b1, 24'd0, 1'b1, 1'b1},
    '{php_pkg::OP_READ,  12'hfff, 11'h000, 1'b1, 24'd2, 1'b1, 1'b1},
    '{php_pkg::OP_READ,  12'h000, 11'h7ff, 1'b1, 24'd2, 1'b1, 1'b1},
    '{php_pkg::OP_PULSE, 12'haaa, 11'h000, 1'b0, 24'd0, 1'b0, 1'b0},
    '{php_pkg::OP_PULSE, 12'h555, 11'h000, 1'b0, 24'd0, 1'b0, 1'b0},
    '{php_pkg::OP_READ,  12'h000, 11'h555, 1'b0, 24'd0, 1'b0, 1'b0},
    '{php_pkg::OP_READ,  12'h000, 11'h2aa, 1'b0, 24'd0, 1'b0, 1'b0},
    '{php_pkg::OP_STOP,  12'h000, 11'h000, 1'b1, 24'd0, 1'b0, 1'b1},
    '{php_pkg::OP_PULSE, 12'h000, 11'h000, 1'b1, 24'd0, 1'b0, 1'b0},
    '{php_pkg::OP_READ,  12'h000, 11'h000, 1'b1, 24'd2, 1'b0, 1'b1},
    '{php_pkg::OP_START, 12'h000, 11'h000, 1'b1, 24'd0, 1'b1, 1'b1},
    '{php_pkg::OP_PULSE, 12'h001, 11'h000, 1'b1, 24'd0, 1'b1, 1'b1},
    '{php_pkg::OP_READ,  12'h000, 11'h000, 1'b1, 24'd3, 1'b1, 1'b1}
  };

  pulse_height_histogram i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic php_pkg::out_item_t bin_event(php_pkg::in_item_t it);
    php_pkg::out_item_t         res;
    logic [php_pkg::BIN_AW-1:0] bin;
    res = '0;
    bin = it.adc_sample[php_pkg::SAMPLE_BITS-1:1];
    case (php_pkg::op_t'(it.op))
      php_pkg::OP_PULSE: begin
        if (run_on && int'(bin) < php_pkg::NUM_BINS) begin
          hist_counts[bin] = hist_counts[bin] + php_pkg::COUNT_W'(1);
          res.accepted = 1'b1;
        end
      end
      php_pkg::OP_START: begin
        if (!run_on) begin
          run_on = 1'b1;
          res.accepted = 1'b1;
        end
      end
      php_pkg::OP_STOP: begin
        if (run_on) begin
          run_on = 1'b0;
          res.accepted = 1'b1;
        end
      end
      default: begin
        if (int'(it.bin_index) < php_pkg::NUM_BINS) begin
          res.bin_count = hist_counts[it.bin_index];
          res.accepted = 1'b1;
        end
      end
    endcase
    res.measuring = run_on;
    return res;
  endfunction

  task automatic add_item(input php_pkg::op_t op, input logic [php_pkg::ADC_W-1:0] adc,
                          input logic [php_pkg::INDEX_W-1:0] idx, input logic quiet);
    stim_t s;
    s = '0;
    s.item.op = op;
    s.item.adc_sample = adc;
    s.item.bin_index = idx;
    s.quiet = quiet;
    stim_q.push_back(s);
  endtask

  // accept and compare at the rising edge; compare first so a fresh transaction
  // can never pair with a stray strobe
  always @(posedge clk) begin
    php_pkg::out_item_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("out_strobe with no transaction pending");
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.bin_count !== want.bin_count) begin
          $error("bin_count: expected %0d, actual %0d", want.bin_count, out_item.bin_count);
          fail_cnt++;
        end
        if (out_item.measuring !== want.measuring) begin
          $error("measuring: expected %0b, actual %0b", want.measuring, out_item.measuring);
          fail_cnt++;
        end
        if (out_item.accepted !== want.accepted) begin
          $error("accepted: expected %0b, actual %0b", want.accepted, out_item.accepted);
          fail_cnt++;
        end
      end
    end
    if (rst_n && start && busy === 1'b0) begin
      want = bin_event(in_item);
      if (row_typed) begin
        want = row_want;
      end
      pending_results.push_back(want);
      accept_cnt++;
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_CAP) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    stim_t                       s;
    logic [php_pkg::INDEX_W-1:0] hot;
    logic [31:0]                 noise_word;
    logic                        quiet;
    int                          burst;
    int                          seen;

    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    row_typed = 1'b0;
    row_want = '0;
    accept_cnt = 0;
    fail_cnt = 0;
    run_on = 1'b0;
    for (int b = 0; b < php_pkg::NUM_BINS; b++) begin
      hist_counts[b] = '0;
    end

    foreach (dir_table[r]) begin
      s = '0;
      s.item.op = dir_table[r].op;
      s.item.adc_sample = dir_table[r].adc;
      s.item.bin_index = dir_table[r].idx;
      s.typed = dir_table[r].typed;
      s.want.bin_count = dir_table[r].cnt;
      s.want.measuring = dir_table[r].meas;
      s.want.accepted = dir_table[r].acc;
      stim_q.push_back(s);
    end

    // measurement bursts around a hot bin, with some random noise transactions
    while (stim_q.size() - DIR_ROWS < RAND_ITEMS) begin
      quiet = (stim_q.size() - DIR_ROWS >= 400) && (stim_q.size() - DIR_ROWS < 700);
      if ($urandom_range(9) == 0) begin
        add_item(php_pkg::op_t'(2'($urandom)), 12'($urandom), 11'($urandom), quiet);
      end else begin
        hot = 11'($urandom);
        add_item(php_pkg::OP_START, 12'($urandom), 11'($urandom), quiet);
        if ($urandom_range(7) == 0) begin
          add_item(php_pkg::OP_START, 12'($urandom), 11'($urandom), quiet);
        end
        burst = $urandom_range(30, 4);
        for (int k = 0; k < burst; k++) begin
          case ($urandom_range(9))
            0, 1, 2, 3: add_item(php_pkg::OP_PULSE, {hot, 1'($urandom)}, 11'($urandom),
                                 quiet);
            4: add_item(php_pkg::OP_PULSE, {hot + 11'd1, 1'($urandom)}, 11'($urandom),
                        quiet);
            5, 6, 7: add_item(php_pkg::OP_PULSE, 12'($urandom), 11'($urandom), quiet);
            8: add_item(php_pkg::OP_READ, 12'($urandom), hot, quiet);
            default: add_item(php_pkg::OP_READ, 12'($urandom), 11'($urandom), quiet);
          endcase
        end
        add_item(php_pkg::OP_READ, 12'($urandom), hot, quiet);
        add_item(php_pkg::OP_STOP, 12'($urandom), 11'($urandom), quiet);
        case ($urandom_range(7))
          0: add_item(php_pkg::OP_STOP, 12'($urandom), 11'($urandom), quiet);
          1: add_item(php_pkg::OP_PULSE, {hot, 1'($urandom)}, 11'($urandom), quiet);
          2: add_item(php_pkg::OP_READ, 12'($urandom), hot, quiet);
          default: ;
        endcase
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_q[n]) begin
      while (!stim_q[n].quiet && $urandom_range(99) < 17) begin
        noise_word = $urandom;
        start = 1'b0;
        row_typed = 1'b0;
        in_item = noise_word[$bits(php_pkg::in_item_t)-1:0];
        @(negedge clk);
      end
      start = 1'b1;
      in_item = stim_q[n].item;
      row_typed = stim_q[n].typed;
      row_want = stim_q[n].want;
      seen = accept_cnt;
      do begin
        @(negedge clk);
      end while (accept_cnt == seen);
    end
    start = 1'b0;
    row_typed = 1'b0;

    while (pending_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (TAIL_WAIT) @(negedge clk);

    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
